/* rtl/core/uart_baud_divisor_calc_assert.svh */
// ----------------------------------------------------------------------------
// UART baud divisor calculator: assertion macros
// Shared property forms for the divisor calculator checks.
// ----------------------------------------------------------------------------
`ifndef UART_BAUD_DIVISOR_CALC_ASSERT_SVH
`define UART_BAUD_DIVISOR_CALC_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UBDC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define UBDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ubdc_pkg.sv */
// ----------------------------------------------------------------------------
// UART baud divisor calculator package
// Widths, register codes, sequencer states and divider status type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ubdc_pkg;

    localparam int BAUD_W     = 22;
    localparam int LOAD_W     = 21;
    localparam int INT_W      = 8;
    localparam int FRAC_W     = 7;
    localparam int M_W        = BAUD_W + 4;   // 16 * baud
    localparam int DIV_W      = 34;           // 4096 * baud and 128 * r + m fit here
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int PRESCALE_SHIFT = 12;       // 16 * 256
    localparam int FRAC_SHIFT     = 7;        // remainder times 128

    localparam logic [APB_DATA_W-1:0] CLK_RESET = 32'd100000000;

    // Register index codes (byte address bit 2)
    localparam logic REG_SOURCE_CLOCK = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_D,
        ST_DIV_Q,
        ST_DIV_IB,
        ST_DIV_FB,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

/* rtl/core/uart_baud_divisor_calc.sv */
// ----------------------------------------------------------------------------
// UART baud divisor calculator
// Turns a requested baud rate into prescaler load, integer and fractional
// divisors for a fractional UART, using one shared serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry i_baud_rate. A request is
//   taken when i_in_valid is high and o_in_stall is low.
//   Output channel: o_out_valid / i_out_stall carry o_timer_load,
//   o_int_divisor, o_frac_divisor and o_bad_rate, one result per request.
//   Configuration: APB-style port, source_clock_hz at byte address 0.
//   Write it only while no request is in flight.
// Sequencing:
//   Four divisions in turn on the shared 34-bit divider: a nonzero rate's
//   result is registered once the fourth division is done and the output
//   register is free, and the next request is taken once the sequencer is
//   back in idle. A zero rate skips the divider and goes straight to output.
//   The divider is the only arithmetic unit, so one request is worked at a
//   time; o_in_stall is high from accept until the result is registered.
// Output stall: the finished result sits in the output register; while it
//   waits, the next request is accepted and computed, and its result holds in
//   the sequencer until the output register frees.
// Reset: synchronous, active low; empties the sequencer and the output
//   register and restores source_clock_hz to 100 MHz.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "uart_baud_divisor_calc_assert.svh"

module uart_baud_divisor_calc #(
    parameter int CLOCK_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    // Request channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [ubdc_pkg::BAUD_W-1:0]        i_baud_rate,

    // Result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [ubdc_pkg::LOAD_W-1:0]        o_timer_load,
    output logic [ubdc_pkg::INT_W-1:0]         o_int_divisor,
    output logic [ubdc_pkg::FRAC_W-1:0]        o_frac_divisor,
    output logic                               o_bad_rate,

    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ubdc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ubdc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ubdc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    // The register is 32 bits; clock bits above CLOCK_BITS are dropped.
    localparam int CW = (CLOCK_BITS < ubdc_pkg::APB_DATA_W) ? CLOCK_BITS
                                                            : ubdc_pkg::APB_DATA_W;
    localparam int DW = ubdc_pkg::DIV_W;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [CW-1:0] r_clk;
    logic          w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2] == ubdc_pkg::REG_SOURCE_CLOCK);
    assign prdata   = (paddr[2] == ubdc_pkg::REG_SOURCE_CLOCK)
                      ? ubdc_pkg::APB_DATA_W'(r_clk) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk <= ubdc_pkg::CLK_RESET[CW-1:0];
        end else if (w_cfg_wr) begin
            r_clk <= pwdata[CW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and result holding registers
    // ------------------------------------------------------------------
    ubdc_pkg::t_state                r_state, n_state;
    logic [ubdc_pkg::BAUD_W-1:0]     r_baud,  n_baud;
    logic [ubdc_pkg::LOAD_W-1:0]     r_load,  n_load;
    logic [ubdc_pkg::INT_W-1:0]      r_int,   n_int;
    logic [ubdc_pkg::FRAC_W-1:0]     r_frac,  n_frac;
    logic                            r_bad,   n_bad;

    // Output register
    logic                            r_out_valid, n_out_valid;
    logic [ubdc_pkg::LOAD_W-1:0]     r_o_load,    n_o_load;
    logic [ubdc_pkg::INT_W-1:0]      r_o_int,     n_o_int;
    logic [ubdc_pkg::FRAC_W-1:0]     r_o_frac,    n_o_frac;
    logic                            r_o_bad,     n_o_bad;

    // Divider hookup
    logic                            w_start;
    logic [DW-1:0]                   w_dividend;
    logic [DW-1:0]                   w_divisor;
    ubdc_pkg::t_div_sts              w_div_sts;
    logic [DW-1:0]                   w_quo;
    logic [DW-1:0]                   w_rem;

    logic                            w_in_acc;
    logic                            w_out_acc;
    logic                            w_qa_zero;
    logic [DW-1:0]                   w_d;
    logic [DW-1:0]                   w_m;
    logic [DW-1:0]                   w_m2;
    logic [DW-1:0]                   w_fb_num;

    // Assertion helpers
    logic                            w_div_act;
    logic                            w_div_step;
    logic                            w_out_clear;
    logic                            w_frac_ok;
    logic                            w_zero_acc;
    logic                            w_st_out;

    assign o_in_stall = (r_state != ubdc_pkg::ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = r_out_valid && !i_out_stall;

    // Prescale d = max(2, clk / (4096 * baud) + 1)
    assign w_qa_zero = (w_quo == '0);
    assign w_d       = w_qa_zero ? DW'(2) : (w_quo + 1'b1);
    // 16 * baud and 2 * 16 * baud
    assign w_m       = DW'({r_baud, 4'b0000});
    assign w_m2      = DW'({r_baud, 5'b00000});
    // Rounded fraction numerator: r * 128 + m, r below m
    assign w_fb_num  = (DW'(w_rem[ubdc_pkg::M_W-1:0]) << ubdc_pkg::FRAC_SHIFT) + w_m;

    always_comb begin
        n_state     = r_state;
        n_baud      = r_baud;
        n_load      = r_load;
        n_int       = r_int;
        n_frac      = r_frac;
        n_bad       = r_bad;
        w_start     = 1'b0;
        w_dividend  = '0;
        w_divisor   = '0;

        n_out_valid = r_out_valid && !w_out_acc;
        n_o_load    = r_o_load;
        n_o_int     = r_o_int;
        n_o_frac    = r_o_frac;
        n_o_bad     = r_o_bad;

        case (r_state)
            ubdc_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_baud = i_baud_rate;
                    if (i_baud_rate == '0) begin
                        // Zero rate: flag it and zero the divisors
                        n_load  = '0;
                        n_int   = '0;
                        n_frac  = '0;
                        n_bad   = 1'b1;
                        n_state = ubdc_pkg::ST_OUT;
                    end else begin
                        // clk / (4096 * baud) as (clk >> 12) / baud
                        n_bad      = 1'b0;
                        w_start    = 1'b1;
                        w_dividend = DW'(r_clk) >> ubdc_pkg::PRESCALE_SHIFT;
                        w_divisor  = DW'(i_baud_rate);
                        n_state    = ubdc_pkg::ST_DIV_D;
                    end
                end
            end
            ubdc_pkg::ST_DIV_D: begin
                if (w_div_sts.done) begin
                    n_load     = w_qa_zero ? ubdc_pkg::LOAD_W'(1)
                                           : w_quo[ubdc_pkg::LOAD_W-1:0];
                    w_start    = 1'b1;
                    w_dividend = DW'(r_clk);
                    w_divisor  = w_d;
                    n_state    = ubdc_pkg::ST_DIV_Q;
                end
            end
            ubdc_pkg::ST_DIV_Q: begin
                if (w_div_sts.done) begin
                    w_start    = 1'b1;
                    w_dividend = w_quo;
                    w_divisor  = w_m;
                    n_state    = ubdc_pkg::ST_DIV_IB;
                end
            end
            ubdc_pkg::ST_DIV_IB: begin
                if (w_div_sts.done) begin
                    n_int      = w_quo[ubdc_pkg::INT_W-1:0];
                    w_start    = 1'b1;
                    w_dividend = w_fb_num;
                    w_divisor  = w_m2;
                    n_state    = ubdc_pkg::ST_DIV_FB;
                end
            end
            ubdc_pkg::ST_DIV_FB: begin
                if (w_div_sts.done) begin
                    n_frac  = w_quo[ubdc_pkg::FRAC_W-1:0];
                    n_state = ubdc_pkg::ST_OUT;
                end
            end
            ubdc_pkg::ST_OUT: begin
                // Hand over once the output register is empty or draining
                if (!r_out_valid || w_out_acc) begin
                    n_out_valid = 1'b1;
                    n_o_load    = r_load;
                    n_o_int     = r_int;
                    n_o_frac    = r_frac;
                    n_o_bad     = r_bad;
                    n_state     = ubdc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ubdc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ubdc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_baud   <= n_baud;
        r_load   <= n_load;
        r_int    <= n_int;
        r_frac   <= n_frac;
        r_bad    <= n_bad;
        r_o_load <= n_o_load;
        r_o_int  <= n_o_int;
        r_o_frac <= n_o_frac;
        r_o_bad  <= n_o_bad;
    end

    // ------------------------------------------------------------------
    // Shared divider
    // ------------------------------------------------------------------
    ubdc_div #(
        .WIDTH (DW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_sts       (w_div_sts),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    assign o_out_valid    = r_out_valid;
    assign o_timer_load   = r_o_load;
    assign o_int_divisor  = r_o_int;
    assign o_frac_divisor = r_o_frac;
    assign o_bad_rate     = r_o_bad;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    assign w_div_act   = w_div_sts.busy || w_div_sts.done;
    assign w_div_step  = r_state inside {ubdc_pkg::ST_DIV_D, ubdc_pkg::ST_DIV_Q,
                                         ubdc_pkg::ST_DIV_IB, ubdc_pkg::ST_DIV_FB};
    assign w_out_clear = (r_o_load == '0) && (r_o_int == '0) && (r_o_frac == '0);
    assign w_frac_ok   = (r_o_frac <= ubdc_pkg::FRAC_W'(64));
    assign w_zero_acc  = w_in_acc && (i_baud_rate == '0);
    assign w_st_out    = (r_state == ubdc_pkg::ST_OUT);

    `UBDC_ASSERT_IMPLIES(a_bad_zeroes, r_out_valid && r_o_bad, w_out_clear, "bad rate, divisors set")
    `UBDC_ASSERT_IMPLIES(a_frac_range, r_out_valid && !r_o_bad, w_frac_ok, "frac divisor above 64")
    `UBDC_ASSERT_IMPLIES(a_div_owned, w_div_act, w_div_step, "divider active outside a divide")
    `UBDC_ASSERT_NEXT(a_zero_rate_fast, w_zero_acc, w_st_out, "zero rate used the divider")

endmodule

/* rtl/core/ubdc_div.sv */
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned divide, one quotient bit per cycle; results hold until next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ubdc_div #(
    parameter int WIDTH = 34
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WIDTH-1:0]     i_dividend,
    input  logic [WIDTH-1:0]     i_divisor,
    output ubdc_pkg::t_div_sts   o_sts,
    output logic [WIDTH-1:0]     o_quotient,
    output logic [WIDTH-1:0]     o_remainder
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH:0]   w_shift;
    logic [WIDTH:0]   w_sub;
    logic             w_ge;
    logic [WIDTH-1:0] n_rem;
    logic [WIDTH-1:0] n_quo;

    always_comb begin
        w_shift = {r_rem, r_quo[WIDTH-1]};
        w_ge    = (w_shift >= {1'b0, r_div});
        w_sub   = w_shift - {1'b0, r_div};
        n_rem   = w_ge ? w_sub[WIDTH-1:0] : w_shift[WIDTH-1:0];
        n_quo   = {r_quo[WIDTH-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WIDTH);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

/* tb/ubdc_divisor_checker.sv */
// ----------------------------------------------------------------------------
// Baud divisor checker
// Watches the request, result and register ports of the divisor calculator,
// predicts each result from the tracked source clock and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ubdc_divisor_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [ubdc_pkg::BAUD_W-1:0]       i_baud_rate,

    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [ubdc_pkg::LOAD_W-1:0]       i_timer_load,
    input  logic [ubdc_pkg::INT_W-1:0]        i_int_divisor,
    input  logic [ubdc_pkg::FRAC_W-1:0]       i_frac_divisor,
    input  logic                              i_bad_rate,

    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic                              i_pready,
    input  logic [ubdc_pkg::APB_ADDR_W-1:0]   i_paddr,
    input  logic [ubdc_pkg::APB_DATA_W-1:0]   i_pwdata,

    output int                                o_pending,
    output int                                o_fail_cnt
);

    localparam int          OVERSAMPLE_SHIFT = 4;      // 16x oversampling
    localparam logic [63:0] MIN_PRESCALE     = 64'd2;
    localparam int          MAX_REPORTS      = 40;

    typedef struct packed {
        logic [ubdc_pkg::LOAD_W-1:0] timer_load;
        logic [ubdc_pkg::INT_W-1:0]  int_divisor;
        logic [ubdc_pkg::FRAC_W-1:0] frac_divisor;
        logic                        bad_rate;
    } t_divisor_set;

    logic [ubdc_pkg::APB_DATA_W-1:0] clock_hz;
    t_divisor_set                    pending_divisors[$];

    // Smallest prescale d >= 2 keeping the integer divisor within 8 bits,
    // then the integer and rounded fractional divisors at that prescale.
    function automatic t_divisor_set calc_divisors(
        input logic [ubdc_pkg::APB_DATA_W-1:0] clk_hz,
        input logic [ubdc_pkg::BAUD_W-1:0]     rate);
        logic [63:0]  clk;
        logic [63:0]  m;
        logic [63:0]  d;
        logic [63:0]  q;
        logic [63:0]  r;
        t_divisor_set res;
        res = '0;
        if (rate == '0) begin
            res.bad_rate = 1'b1;
            return res;
        end
        clk = 64'(clk_hz);
        m   = 64'(rate) << OVERSAMPLE_SHIFT;
        d   = clk / (64'(rate) << ubdc_pkg::PRESCALE_SHIFT) + 64'd1;
        if (d < MIN_PRESCALE) begin
            d = MIN_PRESCALE;
        end
        q = clk / d;
        r = q % m;
        res.timer_load   = ubdc_pkg::LOAD_W'(d - 64'd1);
        res.int_divisor  = ubdc_pkg::INT_W'(q / m);
        res.frac_divisor = ubdc_pkg::FRAC_W'(((r << ubdc_pkg::FRAC_SHIFT) + m) / (m << 1));
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (o_fail_cnt < MAX_REPORTS) begin
            $display("%0t ns: %s", $time, msg);
        end
        o_fail_cnt = o_fail_cnt + 1;
    endtask

    always @(posedge i_clk) begin
        t_divisor_set want;
        if (!i_rst_n) begin
            clock_hz = ubdc_pkg::CLK_RESET;
            pending_divisors.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[ubdc_pkg::APB_ADDR_W-1:2] == ubdc_pkg::REG_SOURCE_CLOCK) begin
                clock_hz = i_pwdata;
            end
            // Pop before push so a result never pairs with its own request.
            if (i_out_valid && !i_out_stall) begin
                if (pending_divisors.size() == 0) begin
                    flag_mismatch($sformatf("result with no request: load %0d int %0d",
                                            i_timer_load, i_int_divisor));
                end else begin
                    want = pending_divisors.pop_front();
                    if (i_timer_load !== want.timer_load)
                        flag_mismatch($sformatf("timer_load got %0d expected %0d",
                                                i_timer_load, want.timer_load));
                    if (i_int_divisor !== want.int_divisor)
                        flag_mismatch($sformatf("int_divisor got %0d expected %0d",
                                                i_int_divisor, want.int_divisor));
                    if (i_frac_divisor !== want.frac_divisor)
                        flag_mismatch($sformatf("frac_divisor got %0d expected %0d",
                                                i_frac_divisor, want.frac_divisor));
                    if (i_bad_rate !== want.bad_rate)
                        flag_mismatch($sformatf("bad_rate got %0b expected %0b",
                                                i_bad_rate, want.bad_rate));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_divisors.push_back(calc_divisors(clock_hz, i_baud_rate));
            end
        end
        o_pending <= pending_divisors.size();
    end

endmodule

/* tb/uart_baud_divisor_calc_test.sv */
// ----------------------------------------------------------------------------
// Baud divisor calculator testbench
// Drives baud rate requests and source clock settings into the calculator,
// with random gaps and result back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_baud_divisor_calc_test;

    localparam int QUIET_LIMIT     = 2000;   // well above the time one request takes
    localparam int DRAIN_CYCLES    = 200;
    localparam int RANDOM_PHASES   = 10;
    localparam int RATES_PER_PHASE = 185;
    localparam int IDLE_PCT        = 9;
    localparam int QUIET_PHASE     = 3;      // phase run without any idling

    localparam logic [ubdc_pkg::BAUD_W-1:0]     RATE_MAX    = 22'd4000000;
    localparam logic [ubdc_pkg::APB_ADDR_W-1:0] CLOCK_ADDR  =
        {ubdc_pkg::REG_SOURCE_CLOCK, 2'b00};
    localparam logic [ubdc_pkg::APB_ADDR_W-1:0] UNUSED_ADDR =
        {~ubdc_pkg::REG_SOURCE_CLOCK, 2'b00};

    // Clock of 9598 Hz with a 100 baud request lands the remainder one short
    // of 16*baud at prescale 2, so the fractional divisor rounds up to 64.
    localparam logic [ubdc_pkg::APB_DATA_W-1:0] CLK_FRAC_TOP = 32'd9598;

    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            i_in_valid     = 1'b0;
    logic                            o_in_stall;
    logic [ubdc_pkg::BAUD_W-1:0]     i_baud_rate    = '0;
    logic                            o_out_valid;
    logic                            i_out_stall    = 1'b0;
    logic [ubdc_pkg::LOAD_W-1:0]     o_timer_load;
    logic [ubdc_pkg::INT_W-1:0]      o_int_divisor;
    logic [ubdc_pkg::FRAC_W-1:0]     o_frac_divisor;
    logic                            o_bad_rate;
    logic                            psel           = 1'b0;
    logic                            penable        = 1'b0;
    logic                            pwrite         = 1'b0;
    logic [ubdc_pkg::APB_ADDR_W-1:0] paddr          = '0;
    logic [ubdc_pkg::APB_DATA_W-1:0] pwdata         = '0;
    logic [ubdc_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    bit idle_on      = 1'b1;
    int pending;
    int fail_cnt;
    int quiet_cycles = 0;

    uart_baud_divisor_calc u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_baud_rate    (i_baud_rate),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_timer_load   (o_timer_load),
        .o_int_divisor  (o_int_divisor),
        .o_frac_divisor (o_frac_divisor),
        .o_bad_rate     (o_bad_rate),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    ubdc_divisor_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_baud_rate    (i_baud_rate),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_timer_load   (o_timer_load),
        .i_int_divisor  (o_int_divisor),
        .i_frac_divisor (o_frac_divisor),
        .i_bad_rate     (o_bad_rate),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_pending      (pending),
        .o_fail_cnt     (fail_cnt)
    );

    always #1 i_clk = ~i_clk;

    // Back-pressure on the result side: stall at random about 9 percent of the time,
    // never while idling is switched off.
    always @(negedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Watchdog: restart on any accepted request, result or register write;
    // give up once the quiet count reaches QUIET_LIMIT with nothing moving.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL uart_baud_divisor_calc");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one request; entered and left at a falling edge. Valid stays
    // high on exit so back-to-back requests need no low cycle between them.
    task automatic send_rate(input logic [ubdc_pkg::BAUD_W-1:0] rate);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid  = 1'b0;
            i_baud_rate = ubdc_pkg::BAUD_W'($urandom);   // junk while idle is ignored
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_baud_rate = rate;
        // Hold the request until an edge sees it with no stall.
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [ubdc_pkg::APB_ADDR_W-1:0] addr,
                             input logic [ubdc_pkg::APB_DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_clock(input logic [ubdc_pkg::APB_DATA_W-1:0] hz);
        drain();
        write_reg(CLOCK_ADDR, hz);
    endtask

    // Mostly full-range rates, a fair share of slow ones to push the
    // prescale up, and an occasional zero rate.
    function automatic logic [ubdc_pkg::BAUD_W-1:0] pick_rate();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            return '0;
        end else if (roll < 25) begin
            return ubdc_pkg::BAUD_W'($urandom_range(1, 1000));
        end
        return ubdc_pkg::BAUD_W'($urandom_range(1, RATE_MAX));
    endfunction

    function automatic logic [ubdc_pkg::APB_DATA_W-1:0] pick_clock();
        case ($urandom_range(0, 5))
            0:       return '1;
            1:       return 32'd1;
            2:       return $urandom;
            3:       return $urandom_range(1_000_000, 200_000_000);
            4:       return $urandom_range(0, 100_000);
            default: return ubdc_pkg::CLK_RESET;
        endcase
    endfunction

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset clock of 100 MHz: zero rate, the rate extremes, common rates.
        send_rate('0);
        send_rate(22'd1);
        send_rate(RATE_MAX);
        send_rate(22'd9600);
        send_rate(22'd115200);

        // A write to an unmapped register must leave the clock alone.
        drain();
        write_reg(UNUSED_ADDR, 32'd12345);
        send_rate(22'd115200);
        send_rate(22'd2);

        // Fractional divisor rounded up to a full 64.
        set_clock(CLK_FRAC_TOP);
        send_rate(22'd100);
        send_rate(22'd1);
        send_rate(RATE_MAX);

        // Slowest clock: prescale 2, both divisors zero.
        set_clock(32'd1);
        send_rate(22'd1);
        send_rate(RATE_MAX);

        // Zero clock falls back to prescale 2 as well.
        set_clock('0);
        send_rate(22'd1);
        send_rate('0);

        // Fastest clock: largest prescale at one baud.
        set_clock('1);
        send_rate(22'd1);
        send_rate(22'd2);
        send_rate(RATE_MAX);
        send_rate('0);

        // Random phases, each at its own source clock.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            idle_on = (phase != QUIET_PHASE);
            if ($urandom_range(0, 3) == 0) begin
                drain();
                write_reg(UNUSED_ADDR, $urandom);
            end
            set_clock(pick_clock());
            for (int n = 0; n < RATES_PER_PHASE; n++) begin
                // Now and then hold off until the calculator has emptied.
                if ($urandom_range(0, 199) == 0) begin
                    drain();
                end
                send_rate(pick_rate());
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("PASS uart_baud_divisor_calc");
        end else begin
            $display("FAIL uart_baud_divisor_calc");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ubdc_pkg.sv
rtl/core/ubdc_div.sv
rtl/core/uart_baud_divisor_calc.sv
tb/ubdc_divisor_checker.sv
tb/uart_baud_divisor_calc_test.sv
